// File: design/cycle_count_timebase_assert.svh
// Assertion macros shared by the timebase checker.
`ifndef CYCLE_COUNT_TIMEBASE_ASSERT_SVH
`define CYCLE_COUNT_TIMEBASE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CCT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CCT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/cct_pkg.sv
// Package with types, codes and constants of the cycle-count timebase.
package cct_pkg;

   localparam int TOTAL_W    = 64;
   localparam int SEC_W      = 45;
   localparam int PART_W     = 10;
   localparam int MICROS_W   = 64;
   localparam int DELTA_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int DIVISOR_W  = 32;
   localparam int CPS_W      = 32;
   localparam int CPM_W      = 23;
   localparam int CPU_W      = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CMD_W      = 2;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 232;
   localparam int RSP_USED_W = TOTAL_W + SEC_W + 2 * PART_W + MICROS_W + DELTA_W;

   localparam int DIV_STEPS  = 64;
   localparam int DIV_CNT_W  = 6;

   localparam logic [PART_W-1:0] PART_MAX = 10'd999;

   localparam logic [CPS_W-1:0] CPS_RESET = 32'd550000000;
   localparam logic [CPM_W-1:0] CPM_RESET = 23'd550000;
   localparam logic [CPU_W-1:0] CPU_RESET = 13'd550;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CPS = 2'd0,
      CSR_CPM = 2'd1,
      CSR_CPU = 2'd2
   } csr_addr_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE  = 2'd0,
      CMD_DELTA   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START1,
      ST_PHASE1,
      ST_START2,
      ST_PHASE2,
      ST_FINISH
   } state_type;

endpackage

// File: design/cct_divider.sv
// Radix-2 restoring divider: one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
module cct_divider
   import cct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TOTAL_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [TOTAL_W-1:0]   quotient,
   output logic [TOTAL_W-1:0]   remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W-1:0]   rq_ff, rq_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;

   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] trial;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, rq_ff[TOTAL_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      fits    = ~trial[DIVISOR_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rq_in   = rq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         zero_in = (divisor == '0);
         cnt_in  = '0;
         rq_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         // A zero divisor leaves the dividend in place as the remainder.
         if (!zero_ff) begin
            rq_in  = {rq_ff[TOTAL_W-2:0], fits};
            rem_in = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         end
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rq_ff   <= rq_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = zero_ff ? '1 : rq_ff;
   assign remainder = zero_ff ? rq_ff : {{(TOTAL_W - DIVISOR_W){1'b0}}, rem_ff};

endmodule

// File: design/cct_accum.sv
// Sample tracker: extends the counter samples into the 64-bit total and forms the delta.
module cct_accum
   import cct_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [CMD_W-1:0]     command,
   input  logic [COUNT_W-1:0]   cycle_count,
   input  logic [COUNT_W-1:0]   earlier_count,
   output logic [TOTAL_W-1:0]   total_cycles,
   output logic [DELTA_W-1:0]   delta_cycles
);

   logic [SAMPLE_WIDTH-1:0] last_ff, last_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;
   logic [DELTA_W-1:0]      delta_ff, delta_in;

   logic [SAMPLE_WIDTH-1:0] now;
   logic [SAMPLE_WIDTH-1:0] earlier;
   logic [SAMPLE_WIDTH-1:0] step;
   logic [SAMPLE_WIDTH-1:0] span;

   always_comb begin
      now     = cycle_count[SAMPLE_WIDTH-1:0];
      earlier = earlier_count[SAMPLE_WIDTH-1:0];
      // Differences wrap modulo the sample width, so a counter rollover is harmless.
      step    = now - last_ff;
      span    = now - earlier;
      last_in  = last_ff;
      total_in = total_ff;
      delta_in = delta_ff;
      if (load) begin
         last_in = now;
         unique case (cmd_type'(command))
            CMD_RESTART: begin
               total_in = '0;
               delta_in = '0;
            end
            CMD_DELTA: begin
               total_in = total_ff + TOTAL_W'(step);
               delta_in = DELTA_W'(span);
            end
            default: begin
               total_in = total_ff + TOTAL_W'(step);
               delta_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         total_ff <= '0;
      end else begin
         last_ff  <= last_in;
         total_ff <= total_in;
      end
      delta_ff <= delta_in;
   end

   assign total_cycles = total_ff;
   assign delta_cycles = delta_ff;

endmodule

// File: design/cycle_count_timebase.sv
// Cycle-count timebase: 64-bit extension of a cycle counter and conversion into time.
//
// Each request transaction carries a counter sample and the earlier sample in req_tdata
// and the command in req_tuser. The block folds the sample into its 64-bit total and
// answers with one response transaction holding the total, whole seconds, the
// millisecond and microsecond parts and total microseconds, plus the delta for a
// delta command. Three bit-serial dividers take one quotient bit per cycle: the first
// pass divides the total by the three rates, the second pass divides the two
// remainders. A request moves through START1, PHASE1, START2, PHASE2 and FINISH before
// its response is loaded into the output register and rsp_tvalid rises.
// req_tready is high only while no request is in work. A finished response sits in the
// output register, and the next request may be taken while it waits. If the receiver
// stalls, the following result waits inside the block until the register is free.
// Reset is synchronous: it zeroes the total and the last sample, loads the default
// rates, clears rsp_tvalid and returns to idle. Rate registers are written through
// the csr port and should change only while the block is idle.
module cycle_count_timebase
   import cct_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // cycle_count[31:0], earlier_count[63:32]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // total_cycles[63:0], whole_seconds[108:64], milli_part[118:109],
   // micro_part[128:119], timeline_micros[192:129], delta_cycles[224:193], zero above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   state_type state_ff, state_in;

   logic [CPS_W-1:0] cps_ff;
   logic [CPM_W-1:0] cpm_ff;
   logic [CPU_W-1:0] cpu_ff;

   logic [SEC_W-1:0]      sec_ff, sec_in;
   logic [MICROS_W-1:0]   micros_ff, micros_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  start1, start2, capture1, load_out;
   logic [TOTAL_W-1:0]    total;
   logic [DELTA_W-1:0]    delta;

   logic [TOTAL_W-1:0]    dvd0, dvd1;
   logic [DIVISOR_W-1:0]  dvs0, dvs1, dvs2;
   logic                  done0, done1, done2;
   logic [TOTAL_W-1:0]    quo0, quo1, quo2;
   logic [TOTAL_W-1:0]    rem0, rem1, rem2;
   logic [PART_W-1:0]     milli_sat, micro_sat;

   assign accept = req_tvalid && req_tready;

   // Rate registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff <= CPS_RESET;
         cpm_ff <= CPM_RESET;
         cpu_ff <= CPU_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_CPS: cps_ff <= csr_wdata[CPS_W-1:0];
            CSR_CPM: cpm_ff <= csr_wdata[CPM_W-1:0];
            CSR_CPU: cpu_ff <= csr_wdata[CPU_W-1:0];
            default: ;
         endcase
      end
   end

   cct_accum #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .command       (req_tuser),
      .cycle_count   (req_tdata[COUNT_W-1:0]),
      .earlier_count (req_tdata[2*COUNT_W-1:COUNT_W]),
      .total_cycles  (total),
      .delta_cycles  (delta)
   );

   // First pass divides the total; second pass divides the two remainders.
   always_comb begin
      if (state_ff == ST_START2) begin
         dvd0 = rem0;
         dvs0 = DIVISOR_W'(cpm_ff);
         dvd1 = rem1;
         dvs1 = DIVISOR_W'(cpu_ff);
      end else begin
         dvd0 = total;
         dvs0 = cps_ff;
         dvd1 = total;
         dvs1 = DIVISOR_W'(cpm_ff);
      end
      dvs2 = DIVISOR_W'(cpu_ff);
   end

   cct_divider u_div0 (
      .clock     (clock),
      .reset     (reset),
      .start     (start1 || start2),
      .dividend  (dvd0),
      .divisor   (dvs0),
      .done      (done0),
      .quotient  (quo0),
      .remainder (rem0)
   );

   cct_divider u_div1 (
      .clock     (clock),
      .reset     (reset),
      .start     (start1 || start2),
      .dividend  (dvd1),
      .divisor   (dvs1),
      .done      (done1),
      .quotient  (quo1),
      .remainder (rem1)
   );

   cct_divider u_div2 (
      .clock     (clock),
      .reset     (reset),
      .start     (start1),
      .dividend  (total),
      .divisor   (dvs2),
      .done      (done2),
      .quotient  (quo2),
      .remainder (rem2)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_START1;
         ST_START1: state_in = ST_PHASE1;
         ST_PHASE1: if (done0 && done1 && done2) state_in = ST_START2;
         ST_START2: state_in = ST_PHASE2;
         ST_PHASE2: if (done0 && done1) state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      start1     = (state_ff == ST_START1);
      start2     = (state_ff == ST_START2);
      capture1   = (state_ff == ST_PHASE1) && done0 && done1 && done2;
      load_out   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      milli_sat = (|quo0[TOTAL_W-1:PART_W] || quo0[PART_W-1:0] > PART_MAX) ?
                  PART_MAX : quo0[PART_W-1:0];
      micro_sat = (|quo1[TOTAL_W-1:PART_W] || quo1[PART_W-1:0] > PART_MAX) ?
                  PART_MAX : quo1[PART_W-1:0];

      sec_in    = sec_ff;
      micros_in = micros_ff;
      if (capture1) begin
         sec_in    = (|quo0[TOTAL_W-1:SEC_W]) ? '1 : quo0[SEC_W-1:0];
         micros_in = quo2;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                         delta, micros_ff, micro_sat, milli_sat, sec_ff, total};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sec_ff      <= sec_in;
      micros_ff   <= micros_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: design/cct_checker.sv
// Port-level checker for the cycle-count timebase and its bind to the top level.
`include "cycle_count_timebase_assert.svh"

module cct_checker
   import cct_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `CCT_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "tready stayed high after a request transaction")
   `CCT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `CCT_ASSERT_NOW(a_pad_zero, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0, "response padding is not zero")
   `CCT_ASSERT_NOW(a_parts_sat, rsp_tvalid, rsp_tdata[118:109] <= PART_MAX && rsp_tdata[128:119] <= PART_MAX, "part exceeds 999")

endmodule

bind cycle_count_timebase cct_checker u_cct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb.sv
// Self-checking testbench for the cycle-count timebase: directed table, then random traffic.
`timescale 1ns / 100ps
module tb;
   import cct_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [SEC_W-1:0] SECONDS_SAT = '1;
   localparam int PHASE_COUNT = 7;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int DIRECTED_COUNT = 18;

   typedef struct packed {
      logic [TOTAL_W-1:0]  total;
      logic [SEC_W-1:0]    secs;
      logic [PART_W-1:0]   milli;
      logic [PART_W-1:0]   micro;
      logic [MICROS_W-1:0] micros;
      logic [DELTA_W-1:0]  delta;
   } timebase_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [COUNT_W-1:0] now;
      logic [COUNT_W-1:0] earlier;
      logic               typed;
      timebase_rsp_type   rsp;
   } stim_row_type;

   localparam timebase_rsp_type ZERO_RSP = '0;
   localparam timebase_rsp_type ONE_SECOND_RSP = '{64'd550000000, 45'd1, 10'd0, 10'd0,
                                                   64'd1000000, 32'd0};
   localparam timebase_rsp_type DELTA_RSP = '{64'd550000550, 45'd1, 10'd0, 10'd1,
                                              64'd1000001, 32'd550};
   localparam timebase_rsp_type HOLD_RSP = '{64'd550000550, 45'd1, 10'd0, 10'd1,
                                             64'd1000001, 32'd0};

   // Rows with typed set carry an expectation that is obvious under the reset rates.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{CMD_UPDATE,  32'd0,          32'd0,          1'b1, ZERO_RSP},
      '{CMD_UPDATE,  32'd550000000,  32'd0,          1'b1, ONE_SECOND_RSP},
      '{CMD_DELTA,   32'd550000550,  32'd550000000,  1'b1, DELTA_RSP},
      '{CMD_UNUSED,  32'd550000550,  32'hFFFFFFFF,   1'b1, HOLD_RSP},
      '{CMD_RESTART, 32'h12345678,   32'hFFFFFFFF,   1'b1, ZERO_RSP},
      '{CMD_UPDATE,  32'hFFFFFFFF,   32'd0,          1'b0, ZERO_RSP},
      '{CMD_DELTA,   32'd0,          32'hFFFFFFFF,   1'b0, ZERO_RSP},
      '{CMD_DELTA,   32'd5,          32'd10,         1'b0, ZERO_RSP},
      '{CMD_UPDATE,  32'h80000000,   32'd0,          1'b0, ZERO_RSP},
      '{CMD_DELTA,   32'hAAAAAAAA,   32'h55555555,   1'b0, ZERO_RSP},
      '{CMD_UPDATE,  32'h55555555,   32'hAAAAAAAA,   1'b0, ZERO_RSP},
      '{CMD_UNUSED,  32'hFFFFFFFF,   32'hFFFFFFFF,   1'b0, ZERO_RSP},
      '{CMD_RESTART, 32'hFFFFFFFF,   32'd0,          1'b1, ZERO_RSP},
      '{CMD_UPDATE,  32'hFFFFFFFF,   32'd0,          1'b1, ZERO_RSP},
      '{CMD_DELTA,   32'hFFFFFFFE,   32'hFFFFFFFF,   1'b0, ZERO_RSP},
      '{CMD_UPDATE,  32'd0,          32'hFFFFFFFF,   1'b0, ZERO_RSP},
      '{CMD_DELTA,   32'd0,          32'd0,          1'b0, ZERO_RSP},
      '{CMD_UPDATE,  32'hFFFFFFFF,   32'h00000001,   1'b0, ZERO_RSP}
   };

   // Rate settings per phase; the first row is the reset value, the last is replaced at random.
   localparam logic [CSR_DATA_W-1:0] RATE_TABLE [PHASE_COUNT][3] = '{
      '{32'd550000000, 32'd550000,  32'd550},
      '{32'd1000000,   32'd1000,    32'd1},
      '{32'd0,         32'd0,       32'd0},
      '{32'hFFFFFFFF,  32'd4294967, 32'd4294},
      '{32'hFFFFFFFF,  32'hFFFFFFFF, 32'hFFFFFFFF},
      '{32'd1,         32'd1,       32'd1},
      '{32'd0,         32'd0,       32'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // cycle_count[31:0], earlier_count[63:32]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // command[1:0]
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // total_cycles[63:0], whole_seconds[108:64], milli_part[118:109],
   // micro_part[128:119], timeline_micros[192:129], delta_cycles[224:193]
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictor state and rate registers.
   logic [CPS_W-1:0]   rate_second = CPS_RESET;
   logic [CPM_W-1:0]   rate_milli = CPM_RESET;
   logic [CPU_W-1:0]   rate_micro = CPU_RESET;
   logic [COUNT_W-1:0] last_sample = '0;
   logic [TOTAL_W-1:0] cycle_total = '0;

   timebase_rsp_type expected_q [$];
   int error_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int req_idle_pct = 6;
   int rsp_idle_pct = 84;

   cycle_count_timebase DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // A zero divisor yields an all-ones quotient and leaves the dividend as remainder.
   function automatic logic [63:0] div_or_ones(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? '1 : n / d;
   endfunction

   function automatic logic [63:0] rem_or_dividend(logic [63:0] n, logic [63:0] d);
      return (d == 0) ? n : n % d;
   endfunction

   function automatic timebase_rsp_type advance_timebase(logic [CMD_W-1:0] cmd,
                                                         logic [COUNT_W-1:0] now,
                                                         logic [COUNT_W-1:0] earlier);
      timebase_rsp_type r;
      logic [COUNT_W-1:0] step;
      logic [63:0] q_sec;
      logic [63:0] q_milli;
      logic [63:0] q_micro;
      r = '0;
      if (cmd == CMD_RESTART) begin
         cycle_total = '0;
      end else begin
         if (cmd == CMD_DELTA) begin
            r.delta = now - earlier;
         end
         step = now - last_sample;
         cycle_total = cycle_total + step;
      end
      last_sample = now;
      r.total = cycle_total;
      q_sec = div_or_ones(cycle_total, rate_second);
      r.secs = (q_sec > SECONDS_SAT) ? SECONDS_SAT : q_sec[SEC_W-1:0];
      q_milli = div_or_ones(rem_or_dividend(cycle_total, rate_second), rate_milli);
      r.milli = (q_milli > PART_MAX) ? PART_MAX : q_milli[PART_W-1:0];
      q_micro = div_or_ones(rem_or_dividend(cycle_total, rate_milli), rate_micro);
      r.micro = (q_micro > PART_MAX) ? PART_MAX : q_micro[PART_W-1:0];
      r.micros = div_or_ones(cycle_total, rate_micro);
      return r;
   endfunction

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [COUNT_W-1:0] now,
                            logic [COUNT_W-1:0] earlier, logic typed,
                            timebase_rsp_type typed_rsp);
      timebase_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {earlier, now};
      do @(posedge clock); while (!req_tready);
      predicted = advance_timebase(cmd, now, earlier);
      expected_q.push_back(typed ? typed_rsp : predicted);
      req_count++;
   endtask

   // Holds the request side off until every outstanding response has been checked.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_rate(csr_addr_type addr, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (addr)
         CSR_CPS: rate_second = value[CPS_W-1:0];
         CSR_CPM: rate_milli = value[CPM_W-1:0];
         CSR_CPU: rate_micro = value[CPU_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      timebase_rsp_type got;
      timebase_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.total = rsp_tdata[63:0];
         got.secs = rsp_tdata[108:64];
         got.milli = rsp_tdata[118:109];
         got.micro = rsp_tdata[128:119];
         got.micros = rsp_tdata[192:129];
         got.delta = rsp_tdata[224:193];
         if (expected_q.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, actual total %0d",
                     $time, got.total);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("total_cycles", want.total, got.total);
            check_field("whole_seconds", 64'(want.secs), 64'(got.secs));
            check_field("milli_part", 64'(want.milli), 64'(got.milli));
            check_field("micro_part", 64'(want.micro), 64'(got.micro));
            check_field("timeline_micros", want.micros, got.micros);
            check_field("delta_cycles", 64'(want.delta), 64'(got.delta));
            rsp_count++;
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] rates [3];
      logic [CMD_W-1:0]      cmd;
      logic [COUNT_W-1:0]    now;
      logic [COUNT_W-1:0]    earlier;
      logic [COUNT_W-1:0]    step;
      int                    pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].now, DIRECTED_ROWS[i].earlier,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 3) begin
            req_idle_pct = 84;
            rsp_idle_pct = 6;
         end else if (phase == 5) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (phase != 0) begin
            rates = RATE_TABLE[phase];
            if (phase == PHASE_COUNT - 1) begin
               rates[0] = $urandom_range(32'hFFFFFFFF, 1000000);
               rates[1] = $urandom_range(4294967, 1000);
               rates[2] = $urandom_range(4294, 1);
            end
            settle_block();
            write_rate(CSR_CPS, rates[0]);
            write_rate(CSR_CPM, rates[1]);
            write_rate(CSR_CPU, rates[2]);
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == ITEMS_PER_PHASE / 2) begin
               settle_block();
            end
            // Mostly forward-moving samples; a share of fully random noise.
            pick = $urandom_range(99);
            if (pick < 45) begin
               cmd = CMD_UPDATE;
            end else if (pick < 75) begin
               cmd = CMD_DELTA;
            end else if (pick < 86) begin
               cmd = CMD_RESTART;
            end else if (pick < 92) begin
               cmd = CMD_UNUSED;
            end else begin
               cmd = CMD_W'($urandom_range(3));
            end
            pick = $urandom_range(99);
            if (pick < 50) begin
               step = $urandom;
            end else if (pick < 75) begin
               step = $urandom_range(2000);
            end else if (pick < 90) begin
               step = rate_second * $urandom_range(3) + $urandom_range(999);
            end else begin
               step = 32'hFFFFFFFF - $urandom_range(255);
            end
            now = last_sample + step;
            if (cmd == CMD_RESTART || $urandom_range(99) < 8) begin
               now = $urandom;
            end
            earlier = ($urandom_range(1) == 0) ? now - $urandom_range(100000) : $urandom;
            send_item(cmd, now, earlier, 1'b0, ZERO_RSP);
         end
      end

      settle_block();
      repeat (200) @(posedge clock);
      $display("Sent %0d requests over %0d rate settings, zero and all-ones rates included;",
               req_count, PHASE_COUNT);
      $display("%0d responses checked with both sides stalling and at full rate.", rsp_count);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding.", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/cct_pkg.sv
design/cct_divider.sv
design/cct_accum.sv
design/cycle_count_timebase.sv
design/cct_checker.sv
tb/tb.sv
